FILE: rtl/core/wqs_pkg.sv
// ----------------------------------------------------------------------------
// wqs_pkg
// Shared types and constants for the waypoint queue sequencer.
// ----------------------------------------------------------------------------
package wqs_pkg;

  localparam int COORD_W  = 24;
  localparam int TIME_W   = 32;
  localparam int RADIUS_W = 20;
  localparam int POINT_W  = 3 * COORD_W;

  // Slave-side tdata: wp_x, wp_y, wp_z, active, pos_valid, pos_north, pos_east, now_ms.
  localparam int IN_BITS = 3 * COORD_W + 2 + 2 * COORD_W + TIME_W;
  localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;

  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = TIME_W;
  localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_HOLD   = 1'b1;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 20'd500;
  localparam logic [TIME_W-1:0]   HOLD_RESET   = 32'd1000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture an accepted request
    logic diff;    // form the coordinate differences
    logic square;  // square the differences and the radius
    logic cmp;     // compare squared distance against squared radius
    logic commit;  // update state and load the output register
  } wqs_cmd_t;

endpackage

FILE: rtl/core/wqs_ctrl.sv
// ----------------------------------------------------------------------------
// wqs_ctrl
// Sequencing state machine and stream handshakes for the sequencer.
// ----------------------------------------------------------------------------
module wqs_ctrl
  import wqs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  output wqs_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIFF = 3'd1;
  localparam logic [2:0] ST_SQR  = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid;

  assign s_tready   = (state == ST_IDLE);
  assign m_tvalid   = out_valid;
  assign cmd.load   = s_tvalid && s_tready;
  assign cmd.diff   = (state == ST_DIFF);
  assign cmd.square = (state == ST_SQR);
  assign cmd.cmp    = (state == ST_CMP);
  // The result may be committed once the output register is empty or draining.
  assign cmd.commit = (state == ST_UPD) && (!out_valid || m_tready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (cmd.load) state_next = ST_DIFF;
      ST_DIFF: state_next = ST_SQR;
      ST_SQR:  state_next = ST_CMP;
      ST_CMP:  state_next = ST_UPD;
      ST_UPD:  if (cmd.commit) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/wqs_datapath.sv
// ----------------------------------------------------------------------------
// wqs_datapath
// Waypoint FIFO, current waypoint state, distance test and result register.
// ----------------------------------------------------------------------------
module wqs_datapath
  import wqs_pkg::*;
#(
  parameter int FIFO_DEPTH = 16,
  parameter int CNT_W      = 5,
  parameter int OUT_W      = 88
) (
  input  logic                  clk,
  input  logic                  rst,
  input  wqs_cmd_t              cmd,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [IN_W-1:0]       in_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_goal,
  output logic [OUT_W-1:0]      out_data
);

  localparam int PTR_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int RES_BITS = POINT_W + 3 + 2 * CNT_W;
  localparam int PAD_W   = OUT_W - RES_BITS;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Configuration.
  logic [RADIUS_W-1:0] radius;
  logic [TIME_W-1:0]   hold;

  // Captured request.
  logic [MODE_W-1:0]         mode_q;
  logic [POINT_W-1:0]        wp_q;
  logic                      act_q;
  logic                      pv_q;
  logic signed [COORD_W-1:0] north_q;
  logic signed [COORD_W-1:0] east_q;
  logic [TIME_W-1:0]         now_q;

  // Sequencer state.
  logic [POINT_W-1:0] fifo_mem [FIFO_DEPTH];
  logic [POINT_W-1:0] rd_q;
  logic [PTR_W-1:0]   head, tail;
  logic [CNT_W-1:0]   count;
  logic               cur_valid;
  logic [POINT_W-1:0] cur_point;
  logic               reached;
  logic [TIME_W-1:0]  rtime;

  // Distance pipeline.
  logic signed [COORD_W:0] dx, dy;
  logic [2*COORD_W+1:0]    dx2, dy2;
  logic [2*RADIUS_W-1:0]   r2;
  logic                    hit;

  logic [PTR_W-1:0]   head_next, tail_next;
  logic [CNT_W-1:0]   count_next;
  logic               cur_valid_next, reached_next;
  logic [POINT_W-1:0] cur_point_next;
  logic [TIME_W-1:0]  rtime_next, rtime_mid, elapsed;
  logic               reach_now, rflag_mid, take_head, push_we, goal, ovf;
  logic [CNT_W-1:0]   dropped;
  logic [POINT_W-1:0] goal_point;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
      hold   <= HOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_RADIUS: radius <= cfg_wdata[RADIUS_W-1:0];
        CFG_HOLD:   hold   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q  <= in_mode;
      wp_q    <= in_data[POINT_W-1:0];
      act_q   <= in_data[POINT_W];
      pv_q    <= in_data[POINT_W+1];
      north_q <= in_data[POINT_W+2 +: COORD_W];
      east_q  <= in_data[POINT_W+2+COORD_W +: COORD_W];
      now_q   <= in_data[POINT_W+2+2*COORD_W +: TIME_W];
    end
  end

  // Vehicle NED is taken as ENU: east against x, north against y.
  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      dx <= {east_q[COORD_W-1], east_q}
          - {cur_point[COORD_W-1], cur_point[COORD_W-1:0]};
      dy <= {north_q[COORD_W-1], north_q}
          - {cur_point[2*COORD_W-1], cur_point[2*COORD_W-1:COORD_W]};
    end
    if (cmd.square) begin
      dx2 <= dx * dx;
      dy2 <= dy * dy;
      r2  <= radius * radius;
    end
    if (cmd.cmp) begin
      hit <= ({1'b0, dx2} + {1'b0, dy2}) <= (2*COORD_W+3)'(r2);
    end
  end

  // The head entry is read every cycle; head only moves on a commit.
  always_ff @(posedge clk) begin
    rd_q <= fifo_mem[head];
    if (cmd.commit && push_we) begin
      fifo_mem[tail] <= wp_q;
    end
  end

  always_comb begin
    head_next      = head;
    tail_next      = tail;
    count_next     = count;
    cur_valid_next = cur_valid;
    reached_next   = reached;
    cur_point_next = cur_point;
    rtime_next     = rtime;
    take_head      = 1'b0;
    push_we        = 1'b0;
    goal           = 1'b0;
    ovf            = 1'b0;
    dropped        = '0;

    reach_now = !reached && pv_q && hit;
    rflag_mid = reached || reach_now;
    rtime_mid = reach_now ? now_q : rtime;
    elapsed   = now_q - rtime_mid;

    case (mode_q)
      MODE_PUSH: begin
        if (count == CNT_W'(FIFO_DEPTH)) begin
          ovf = 1'b1;
        end else begin
          push_we    = 1'b1;
          tail_next  = ptr_inc(tail);
          count_next = count + 1'b1;
        end
      end
      MODE_TICK: begin
        if (act_q) begin
          if (cur_valid) begin
            rtime_next   = rtime_mid;
            reached_next = rflag_mid;
            if (rflag_mid && (elapsed >= hold)) begin
              cur_valid_next = 1'b0;
              reached_next   = 1'b0;
              take_head      = 1'b1;
            end
          end else begin
            take_head = 1'b1;
          end
        end
      end
      MODE_CLEAR: begin
        dropped        = count;
        count_next     = '0;
        head_next      = '0;
        tail_next      = '0;
        cur_valid_next = 1'b0;
        reached_next   = 1'b0;
      end
      default: ;
    endcase

    if (take_head && (count != '0)) begin
      cur_point_next = rd_q;
      head_next      = ptr_inc(head);
      count_next     = count - 1'b1;
      cur_valid_next = 1'b1;
      reached_next   = 1'b0;
      goal           = 1'b1;
    end

    goal_point = goal ? cur_point_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      cur_valid <= 1'b0;
      cur_point <= '0;
      reached   <= 1'b0;
      rtime     <= '0;
    end else if (cmd.commit) begin
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      cur_valid <= cur_valid_next;
      cur_point <= cur_point_next;
      reached   <= reached_next;
      rtime     <= rtime_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_goal <= goal;
      out_data <= {{PAD_W{1'b0}}, ovf, dropped, count_next, reached_next,
                   cur_valid_next, goal_point};
    end
  end

endmodule

FILE: rtl/core/waypoint_queue_sequencer_unit.sv
// ----------------------------------------------------------------------------
// waypoint_queue_sequencer_unit
// Waypoint FIFO with a pursue, reach and hold sequence on one current waypoint.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Signals                      Carries
//  s        in         s_tvalid/s_tready/s_tdata    push, tick or clear request
//                      s_tuser                      request kind
//  m        out        m_tvalid/m_tready/m_tdata    one status result per request
//                      m_tuser                      goal issued flag
//  cfg      in         cfg_we/cfg_addr/cfg_wdata    reach radius, hold time
//
// Each request passes through capture, coordinate difference, squaring,
// distance compare, and state update with the output register load.
// A request is taken only while the sequencer is idle, so one request
// completes before the next. The update waits while the output register
// still holds an untaken result, and no new request is taken until it is done.
// Synchronous reset empties the FIFO and drops the current waypoint.
//
module waypoint_queue_sequencer_unit
  import wqs_pkg::*;
#(
  parameter int FIFO_DEPTH = 16,
  localparam int CNT_W     = $clog2(FIFO_DEPTH + 1),
  localparam int OUT_W     = ((POINT_W + 3 + 2 * CNT_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // wp_x, wp_y, wp_z, active, pos_valid, pos_north, pos_east, now_ms, zero pad
  input  logic [IN_W-1:0]       s_tdata,
  // mode
  input  logic [MODE_W-1:0]     s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // goal_x, goal_y, goal_z, pursuing, reached, pending_count, dropped_count,
  // overflow, zero pad
  output logic [OUT_W-1:0]      m_tdata,
  // goal_valid
  output logic                  m_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  wqs_cmd_t cmd;

  wqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  wqs_datapath #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .CNT_W      (CNT_W),
    .OUT_W      (OUT_W)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_mode   (s_tuser),
    .in_data   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_goal  (m_tuser),
    .out_data  (m_tdata)
  );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for waypoint_queue_sequencer_unit. Waypoint pushes,
// position ticks, clears and unused request kinds are streamed in with random
// gaps and output back-pressure. A behavioral sequencer tracks the waypoint
// ring, the current target and its hold timer, and every status result is
// compared field by field against the status it predicts.
// ----------------------------------------------------------------------------
module tb_top;
  import wqs_pkg::*;

  localparam int FIFO_DEPTH  = 16;
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
  localparam int STATUS_BITS = POINT_W + 3 + 2 * CNT_W;
  localparam int OUT_W       = ((STATUS_BITS + 7) / 8) * 8;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [TIME_W-1:0] WRAP_MS     = 32'hFFFF_FE00;
  localparam int LONG_STALL_AFTER = 150;
  localparam int LONG_STALL       = 300;
  localparam int STALL_LIMIT      = 4000;
  localparam int PLAN_MAX         = 2048;

  typedef struct {
    logic [MODE_W-1:0]         mode;
    logic signed [COORD_W-1:0] wp_x;
    logic signed [COORD_W-1:0] wp_y;
    logic signed [COORD_W-1:0] wp_z;
    logic                      active;
    logic                      pos_valid;
    logic signed [COORD_W-1:0] pos_north;
    logic signed [COORD_W-1:0] pos_east;
    logic [TIME_W-1:0]         now_ms;
  } wq_req_t;

  typedef struct {
    logic                      goal_valid;
    logic signed [COORD_W-1:0] goal_x;
    logic signed [COORD_W-1:0] goal_y;
    logic signed [COORD_W-1:0] goal_z;
    logic                      pursuing;
    logic                      reached;
    logic [CNT_W-1:0]          pending;
    logic [CNT_W-1:0]          dropped;
    logic                      overflow;
  } wq_status_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata   = '0;
  logic [MODE_W-1:0]     s_tuser   = MODE_PUSH;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_W-1:0]      m_tdata;
  logic                  m_tuser;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_RADIUS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  waypoint_queue_sequencer_unit #(.FIFO_DEPTH(FIFO_DEPTH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sequencer state as the block should hold it.
  logic [RADIUS_W-1:0] radius_cfg = RADIUS_RESET;
  logic [TIME_W-1:0]   hold_cfg   = HOLD_RESET;
  point_t              wp_ring [FIFO_DEPTH];
  int                  ring_rd    = 0;
  int                  ring_wr    = 0;
  logic [CNT_W-1:0]    ring_fill  = '0;
  logic                target_on  = 1'b0;
  point_t              target_pt  = '{default: '0};
  logic                target_hit = 1'b0;
  logic [TIME_W-1:0]   hit_ms     = '0;

  // Pending requests and expected results, each read in order by index.
  wq_req_t    request_buf [PLAN_MAX];
  int         req_head      = 0;
  int         req_tail      = 0;
  wq_status_t status_buf [PLAN_MAX];
  int         due_head      = 0;
  int         due_tail      = 0;
  int         planned       = 0;
  int         mismatches    = 0;
  int         results_seen  = 0;
  int         send_gap      = 0;
  int         stall_left    = 0;
  int         quiet_cycles  = 0;
  bit         long_stall_done = 1'b0;
  bit         no_idle       = 1'b0;
  logic [TIME_W-1:0] plan_ms;

  task automatic issue_next_goal(inout wq_status_t st);
    if (ring_fill != '0) begin
      target_pt  = wp_ring[ring_rd];
      ring_rd    = (ring_rd + 1) % FIFO_DEPTH;
      ring_fill  = ring_fill - 1'b1;
      target_on  = 1'b1;
      target_hit = 1'b0;
      st.goal_valid = 1'b1;
      st.goal_x     = target_pt.x;
      st.goal_y     = target_pt.y;
      st.goal_z     = target_pt.z;
    end
  endtask

  task automatic advance_sequencer(input wq_req_t r, output wq_status_t st);
    longint            dx;
    longint            dy;
    longint unsigned   dist2;
    longint unsigned   rad;
    logic [TIME_W-1:0] elapsed;
    st = '{default: '0};
    case (r.mode)
      MODE_PUSH: begin
        if (ring_fill == CNT_W'(FIFO_DEPTH)) begin
          st.overflow = 1'b1;
        end else begin
          wp_ring[ring_wr] = '{r.wp_x, r.wp_y, r.wp_z};
          ring_wr   = (ring_wr + 1) % FIFO_DEPTH;
          ring_fill = ring_fill + 1'b1;
        end
      end
      MODE_TICK: begin
        if (r.active && target_on) begin
          // Position arrives in NED: east is compared with x, north with y.
          if (!target_hit && r.pos_valid) begin
            dx    = longint'(r.pos_east) - longint'(target_pt.x);
            dy    = longint'(r.pos_north) - longint'(target_pt.y);
            dist2 = longint'(dx * dx) + longint'(dy * dy);
            rad   = 64'(radius_cfg);
            if (dist2 <= rad * rad) begin
              target_hit = 1'b1;
              hit_ms     = r.now_ms;
            end
          end
          elapsed = r.now_ms - hit_ms;
          if (target_hit && elapsed >= hold_cfg) begin
            target_on  = 1'b0;
            target_hit = 1'b0;
            issue_next_goal(st);
          end
        end else if (r.active) begin
          issue_next_goal(st);
        end
      end
      MODE_CLEAR: begin
        st.dropped = ring_fill;
        ring_fill  = '0;
        ring_rd    = 0;
        ring_wr    = 0;
        target_on  = 1'b0;
        target_hit = 1'b0;
      end
      default: begin
      end
    endcase
    st.pursuing = target_on;
    st.reached  = target_hit;
    st.pending  = ring_fill;
  endtask

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Request driver: takes the plan in order, with random gaps between requests.
  always @(posedge clk) begin
    wq_req_t r;
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else if (!s_tvalid || s_tready) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (req_head < req_tail) begin
        r = request_buf[req_head];
        req_head++;
        s_tvalid <= 1'b1;
        s_tuser  <= r.mode;
        s_tdata  <= IN_W'({r.now_ms, r.pos_east, r.pos_north, r.pos_valid, r.active,
                           r.wp_z, r.wp_y, r.wp_x});
        if (!no_idle && $urandom_range(0, 99) < 25) send_gap = $urandom_range(1, 11);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: short random stalls, plus one long hold-off that lets
  // the block back up and stall its input.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (!long_stall_done && results_seen >= LONG_STALL_AFTER) begin
        stall_left = LONG_STALL;
        long_stall_done = 1'b1;
      end else if (stall_left == 0 && !no_idle && $urandom_range(0, 99) < 20) begin
        stall_left = $urandom_range(1, 11);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on each accepted request, checks each accepted result.
  always @(posedge clk) begin
    wq_req_t    r;
    wq_status_t want;
    wq_status_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        r.mode = s_tuser;
        {r.now_ms, r.pos_east, r.pos_north, r.pos_valid, r.active,
         r.wp_z, r.wp_y, r.wp_x} = s_tdata[IN_BITS-1:0];
        advance_sequencer(r, want);
        status_buf[due_tail] = want;
        due_tail++;
      end
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        got.goal_valid = m_tuser;
        {got.overflow, got.dropped, got.pending, got.reached, got.pursuing,
         got.goal_z, got.goal_y, got.goal_x} = m_tdata[STATUS_BITS-1:0];
        if (due_head == due_tail) begin
          $error("status result with no request outstanding");
          mismatches++;
        end else begin
          want = status_buf[due_head];
          due_head++;
          check_field("goal_valid", 64'(want.goal_valid), 64'(got.goal_valid));
          check_field("goal_x", 64'(want.goal_x), 64'(got.goal_x));
          check_field("goal_y", 64'(want.goal_y), 64'(got.goal_y));
          check_field("goal_z", 64'(want.goal_z), 64'(got.goal_z));
          check_field("pursuing", 64'(want.pursuing), 64'(got.pursuing));
          check_field("reached", 64'(want.reached), 64'(got.reached));
          check_field("pending_count", 64'(want.pending), 64'(got.pending));
          check_field("dropped_count", 64'(want.dropped), 64'(got.dropped));
          check_field("overflow", 64'(want.overflow), 64'(got.overflow));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  function automatic wq_req_t random_request();
    wq_req_t r;
    r.mode      = MODE_TICK;
    r.wp_x      = COORD_W'($urandom);
    r.wp_y      = COORD_W'($urandom);
    r.wp_z      = COORD_W'($urandom);
    r.active    = 1'($urandom_range(0, 1));
    r.pos_valid = 1'($urandom_range(0, 1));
    r.pos_north = COORD_W'($urandom);
    r.pos_east  = COORD_W'($urandom);
    r.now_ms    = $urandom;
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 11))
      0:       return 24'sh7FFFFF;
      1:       return 24'sh800000;
      2:       return '0;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp24(input longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[COORD_W-1:0];
  endfunction

  task automatic add_request(input wq_req_t r);
    request_buf[req_tail] = r;
    req_tail++;
    planned++;
  endtask

  task automatic send_push(input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y,
                           input logic signed [COORD_W-1:0] z);
    wq_req_t r;
    r = random_request();
    r.mode = MODE_PUSH;
    r.wp_x = x;
    r.wp_y = y;
    r.wp_z = z;
    add_request(r);
  endtask

  task automatic send_tick(input logic act, input logic pv,
                           input logic signed [COORD_W-1:0] north,
                           input logic signed [COORD_W-1:0] east,
                           input logic [TIME_W-1:0] now);
    wq_req_t r;
    r = random_request();
    r.active    = act;
    r.pos_valid = pv;
    r.pos_north = north;
    r.pos_east  = east;
    r.now_ms    = now;
    add_request(r);
  endtask

  task automatic send_kind(input logic [MODE_W-1:0] kind);
    wq_req_t r;
    r = random_request();
    r.mode = kind;
    add_request(r);
  endtask

  // Requests that leave a target which is not yet reached unchanged.
  task automatic send_noise();
    case ($urandom_range(0, 2))
      0:       send_kind(MODE_UNUSED);
      1:       send_tick(1'b0, 1'($urandom_range(0, 1)), COORD_W'($urandom),
                         COORD_W'($urandom), $urandom);
      default: send_tick(1'b1, 1'b0, COORD_W'($urandom), COORD_W'($urandom), plan_ms);
    endcase
  endtask

  // One route: push waypoints, start the first, then for each one approach, arrive
  // within the radius, at times wait part of the hold and finally move on.
  task automatic plan_route();
    logic signed [COORD_W-1:0] rx [FIFO_DEPTH];
    logic signed [COORD_W-1:0] ry [FIFO_DEPTH];
    int                n;
    int                cut;
    int                off;
    logic [TIME_W-1:0] t_hit;
    logic [TIME_W-1:0] extra_max;
    if ($urandom_range(0, 9) == 0) begin
      // Overfill the ring, then throw it away.
      repeat ($urandom_range(FIFO_DEPTH, FIFO_DEPTH + 3))
        send_push(pick_coord(), pick_coord(), pick_coord());
      send_kind(MODE_CLEAR);
      return;
    end
    n   = ($urandom_range(0, 9) == 0) ? $urandom_range(5, FIFO_DEPTH) : $urandom_range(1, 4);
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n;
    off = int'(radius_cfg >> 1);
    for (int k = 0; k < n; k++) begin
      rx[k] = pick_coord();
      ry[k] = pick_coord();
      send_push(rx[k], ry[k], pick_coord());
    end
    plan_ms += $urandom_range(1, 100);
    send_tick(1'b1, 1'($urandom_range(0, 1)), COORD_W'($urandom), COORD_W'($urandom),
              plan_ms);
    for (int k = 0; k < n; k++) begin
      if (k == cut) begin
        send_kind(MODE_CLEAR);
        return;
      end
      if ($urandom_range(0, 3) == 0) send_noise();
      plan_ms += $urandom_range(1, 100);
      send_tick(1'b1, 1'b1,
                clamp24(longint'(ry[k]) + longint'($urandom_range(0, 2 * off)) - off),
                clamp24(longint'(rx[k]) + longint'($urandom_range(0, 2 * off)) - off),
                plan_ms);
      t_hit = plan_ms;
      if (hold_cfg != '0 && $urandom_range(0, 1) == 1)
        send_tick(1'b1, 1'($urandom_range(0, 1)), COORD_W'($urandom), COORD_W'($urandom),
                  t_hit + $urandom_range(0, hold_cfg - 1));
      // Near the top of the hold range a larger overshoot would wrap around.
      extra_max = (hold_cfg > 32'hFFFF_FF00) ? ~hold_cfg : 32'd200;
      plan_ms   = t_hit + hold_cfg + $urandom_range(0, extra_max);
      send_tick(1'b1, 1'($urandom_range(0, 1)), COORD_W'($urandom), COORD_W'($urandom),
                plan_ms);
    end
  endtask

  task automatic drain();
    while (req_head != req_tail || s_tvalid || due_head != due_tail) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_RADIUS) radius_cfg = val[RADIUS_W-1:0];
    else hold_cfg = val;
  endtask

  task automatic set_regs(input logic [RADIUS_W-1:0] radius, input logic [TIME_W-1:0] hold);
    drain();
    repeat (8) @(posedge clk);
    write_reg(CFG_RADIUS, CFG_DATA_W'(radius));
    write_reg(CFG_HOLD, hold);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed requests at the reset settings: radius 500, hold 1000.
    send_kind(MODE_UNUSED);
    send_tick(1'b1, 1'b1, '0, '0, 32'd10);
    send_push(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send_push(24'sh800000, 24'sh800000, 24'sh800000);
    repeat (FIFO_DEPTH - 2) send_push(pick_coord(), pick_coord(), pick_coord());
    send_push(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
    send_tick(1'b0, 1'b1, '0, '0, 32'd20);
    send_tick(1'b1, 1'b1, 24'sh800000, 24'sh800000, 32'd30);
    send_tick(1'b1, 1'b0, 24'sh7FFFFF, 24'sh7FFFFF, 32'd40);
    send_tick(1'b1, 1'b1, 24'sh7FFFFF, 24'sh7FFFFF, WRAP_MS);
    send_tick(1'b1, 1'b1, '0, '0, WRAP_MS + 32'd999);
    send_tick(1'b1, 1'b1, '0, '0, WRAP_MS + 32'd1000);
    // Exactly on the radius: 300 north and 400 east of the corner.
    send_tick(1'b1, 1'b1, -24'sd8388308, -24'sd8388208, WRAP_MS + 32'd1500);
    send_tick(1'b1, 1'b0, '0, '0, WRAP_MS + 32'd2500);
    send_kind(MODE_CLEAR);

    plan_ms = $urandom;
    while (planned < 100) plan_route();
    set_regs('0, '0);
    while (planned < 200) plan_route();
    set_regs('1, '1);
    while (planned < 300) plan_route();
    set_regs(RADIUS_W'($urandom_range(1, 4000)), $urandom_range(1, 5000));
    while (planned < 400) plan_route();
    set_regs(RADIUS_RESET, HOLD_RESET);
    no_idle = 1'b1;
    while (planned < 500) plan_route();

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
